FILE: hw/rtl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants of the per-source rate limiter
// Holds the request classes, table row layout, result codes and register map.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int Q_DEPTH           = 4;
  localparam int Q_PTR_W           = 2;
  localparam int STAMP_W           = 48;

  localparam logic [15:0] ETH_HEADER_BYTES = 16'd14;
  localparam logic [15:0] IPV4_MIN_FRAME   = 16'd34;
  localparam logic [15:0] KIND_IPV4        = 16'h0800;
  localparam logic [63:0] ONE_SECOND_NS    = 64'd1000000000;
  localparam logic [31:0] PACKETS_MAX      = 32'hFFFF_FFFF;
  localparam logic [39:0] BYTES_MAX        = 40'hFF_FFFF_FFFF;

  localparam logic [31:0] PACKET_LIMIT_RST = 32'd100;
  localparam logic [31:0] BYTE_LIMIT_RST   = 32'd100000;

  // Register indexes (word addresses)
  localparam logic [1:0] REG_PACKET_LIMIT    = 2'd0;
  localparam logic [1:0] REG_BYTE_LIMIT      = 2'd1;
  localparam logic [1:0] REG_UNBLOCK_SECONDS = 2'd2;
  localparam logic [1:0] REG_UNBLOCK_ENABLED = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_ABORT = 2'd2;

  // Cause codes
  localparam logic [2:0] CAUSE_NOT_IPV4  = 3'd0;
  localparam logic [2:0] CAUSE_WITHIN    = 3'd1;
  localparam logic [2:0] CAUSE_STILL     = 3'd2;
  localparam logic [2:0] CAUSE_NEW_BLOCK = 3'd3;
  localparam logic [2:0] CAUSE_RELEASED  = 3'd4;
  localparam logic [2:0] CAUSE_MALFORMED = 3'd5;

  typedef enum logic [1:0] {
    CLS_SHORT,
    CLS_NONIP,
    CLS_IPV4
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] src;
    logic [15:0] bytes;
    logic [63:0] now;
  } q_item_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        key;
    logic               blocked;
    logic [STAMP_W-1:0] stamp;
    logic [31:0]        packets;
    logic [39:0]        bytes;
    logic [63:0]        wend;
  } row_t;

  typedef struct packed {
    logic [31:0] packet_limit;
    logic [31:0] byte_limit;
    logic [61:0] delay_ns;
    logic        unblock_enabled;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EVAL1,
    ST_EVAL2
  } bk_state_t;

endpackage

FILE: hw/rtl/psrl_front.sv
// ----------------------------------------------------------------------------
// psrl_front: input stage
// Accepts frame requests and classifies them as short, non-IPv4 or IPv4.
// ----------------------------------------------------------------------------
module psrl_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,
  input  logic              q_full,
  output logic              push,
  output psrl_pkg::q_item_t push_item
);

  logic [15:0] frame_length;
  logic [15:0] ether_kind;

  assign frame_length = in_tdata[15:0];
  assign ether_kind   = in_tdata[31:16];

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // Classify the frame
  always_comb begin
    push_item.src   = in_tdata[63:32];
    push_item.now   = in_tdata[127:64];
    push_item.bytes = frame_length - psrl_pkg::ETH_HEADER_BYTES;
    if (frame_length < psrl_pkg::ETH_HEADER_BYTES) begin
      push_item.cls = psrl_pkg::CLS_SHORT;
    end else if (ether_kind != psrl_pkg::KIND_IPV4) begin
      push_item.cls = psrl_pkg::CLS_NONIP;
    end else if (frame_length < psrl_pkg::IPV4_MIN_FRAME) begin
      push_item.cls = psrl_pkg::CLS_SHORT;
    end else begin
      push_item.cls = psrl_pkg::CLS_IPV4;
    end
  end

endmodule

FILE: hw/rtl/psrl_queue.sv
// ----------------------------------------------------------------------------
// psrl_queue: short request queue
// Decouples the classifying front from the table engine.
// ----------------------------------------------------------------------------
module psrl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  psrl_pkg::q_item_t push_item,
  input  logic              pop,
  output logic              q_valid,
  output logic              q_full,
  output psrl_pkg::q_item_t q_item
);

  psrl_pkg::q_item_t slots_r [psrl_pkg::Q_DEPTH];
  logic [psrl_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [psrl_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [psrl_pkg::Q_PTR_W:0]   count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (psrl_pkg::Q_PTR_W + 1)'(psrl_pkg::Q_DEPTH));
  assign q_item  = slots_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/psrl_back.sv
// ----------------------------------------------------------------------------
// psrl_back: table engine
// Scans the source table, updates window counts and blocks, emits verdicts.
// ----------------------------------------------------------------------------
module psrl_back #(
  parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psrl_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  psrl_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

  psrl_pkg::bk_state_t state_r, state_nxt;

  psrl_pkg::row_t mem [TABLE_ENTRIES];
  psrl_pkg::row_t mem_q;
  psrl_pkg::row_t wr_row;
  logic           mem_we;
  logic [IDX_W-1:0] waddr;

  logic [IDX_W-1:0] clr_cnt_r;
  logic [CNT_W-1:0] issue_cnt_r;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [psrl_pkg::STAMP_W-1:0] stamp_ctr_r;

  psrl_pkg::q_item_t item_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  psrl_pkg::row_t    hit_row_r;
  logic              inv_r;
  logic [IDX_W-1:0]  inv_idx_r;
  logic              minv_r;
  logic [IDX_W-1:0]  min_idx_r;
  logic [psrl_pkg::STAMP_W-1:0] min_stamp_r;

  logic [IDX_W-1:0] slot_r;
  logic [63:0]      new_end_r;
  logic             gt_r;
  logic             ge_r;
  logic [63:0]      diff_r;
  logic [31:0]      pk_inc_r;
  logic [39:0]      by_sum_r;

  logic       out_v_r;
  logic [1:0] verdict_r, verdict_nxt;
  logic [2:0] cause_r, cause_nxt;
  logic       can_load;
  logic       load_out;
  logic       release_ok;
  logic [40:0] by_wide;
  logic [39:0] item_bytes;

  assign can_load   = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, cause_r, verdict_r};
  assign item_bytes = 40'(item_r.bytes);
  assign by_wide    = {1'b0, hit_row_r.bytes} + 41'(item_r.bytes);

  // Next state, queue pop, table write and result codes
  always_comb begin
    state_nxt   = state_r;
    q_pop       = 1'b0;
    load_out    = 1'b0;
    mem_we      = 1'b0;
    waddr       = clr_cnt_r;
    wr_row      = '0;
    verdict_nxt = psrl_pkg::VERDICT_PASS;
    cause_nxt   = psrl_pkg::CAUSE_NOT_IPV4;
    release_ok  = cfg.unblock_enabled && ge_r && (diff_r >= {2'b00, cfg.delay_ns});
    case (state_r)
      psrl_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = psrl_pkg::ST_IDLE;
        end
      end
      psrl_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.cls)
            psrl_pkg::CLS_IPV4: begin
              q_pop     = 1'b1;
              state_nxt = psrl_pkg::ST_SCAN;
            end
            psrl_pkg::CLS_NONIP: begin
              q_pop    = can_load;
              load_out = can_load;
            end
            default: begin
              q_pop       = can_load;
              load_out    = can_load;
              verdict_nxt = psrl_pkg::VERDICT_ABORT;
              cause_nxt   = psrl_pkg::CAUSE_MALFORMED;
            end
          endcase
        end
      end
      psrl_pkg::ST_SCAN: begin
        if (rd_v_r && rd_idx_r == LAST_IDX) begin
          state_nxt = psrl_pkg::ST_EVAL1;
        end
      end
      psrl_pkg::ST_EVAL1: begin
        state_nxt = psrl_pkg::ST_EVAL2;
      end
      psrl_pkg::ST_EVAL2: begin
        waddr         = slot_r;
        wr_row        = hit_row_r;
        wr_row.valid  = 1'b1;
        wr_row.key    = item_r.src;
        wr_row.stamp  = stamp_ctr_r;
        if (hit_r && hit_row_r.blocked) begin
          if (release_ok) begin
            wr_row.blocked = 1'b0;
            wr_row.packets = 32'd1;
            wr_row.bytes   = item_bytes;
            wr_row.wend    = new_end_r;
            cause_nxt      = psrl_pkg::CAUSE_RELEASED;
          end else begin
            verdict_nxt = psrl_pkg::VERDICT_DROP;
            cause_nxt   = psrl_pkg::CAUSE_STILL;
          end
        end else begin
          if (!hit_r || gt_r) begin
            wr_row.packets = 32'd1;
            wr_row.bytes   = item_bytes;
            wr_row.wend    = new_end_r;
          end else begin
            wr_row.packets = pk_inc_r;
            wr_row.bytes   = by_sum_r;
          end
          if (wr_row.packets > cfg.packet_limit ||
              wr_row.bytes > {8'h00, cfg.byte_limit}) begin
            wr_row.blocked = 1'b1;
            verdict_nxt    = psrl_pkg::VERDICT_DROP;
            cause_nxt      = psrl_pkg::CAUSE_NEW_BLOCK;
          end else begin
            wr_row.blocked = 1'b0;
            cause_nxt      = psrl_pkg::CAUSE_WITHIN;
          end
        end
        if (can_load) begin
          mem_we    = 1'b1;
          load_out  = 1'b1;
          state_nxt = psrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psrl_pkg::ST_CLEAR;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psrl_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      issue_cnt_r <= '0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      stamp_ctr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == psrl_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == psrl_pkg::ST_SCAN && issue_cnt_r != CNT_END) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
        rd_v_r      <= 1'b1;
      end else begin
        issue_cnt_r <= (state_r == psrl_pkg::ST_SCAN) ? issue_cnt_r : '0;
        rd_v_r      <= 1'b0;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (state_r == psrl_pkg::ST_EVAL2 && can_load) begin
        stamp_ctr_r <= stamp_ctr_r + 1'b1;
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wr_row;
    end
    mem_q <= mem[issue_cnt_r[IDX_W-1:0]];
  end

  // Scan the table for a hit, a free entry and the least recent entry
  always_ff @(posedge clk) begin
    rd_idx_r <= issue_cnt_r[IDX_W-1:0];
    if (q_pop) begin
      item_r <= q_item;
      hit_r  <= 1'b0;
      inv_r  <= 1'b0;
      minv_r <= 1'b0;
    end else if (state_r == psrl_pkg::ST_SCAN && rd_v_r) begin
      if (mem_q.valid && mem_q.key == item_r.src && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_row_r <= mem_q;
      end
      if (!mem_q.valid && !inv_r) begin
        inv_r     <= 1'b1;
        inv_idx_r <= rd_idx_r;
      end
      if (mem_q.valid && (!minv_r || mem_q.stamp < min_stamp_r)) begin
        minv_r      <= 1'b1;
        min_idx_r   <= rd_idx_r;
        min_stamp_r <= mem_q.stamp;
      end
    end
  end

  // Precompute window arithmetic
  always_ff @(posedge clk) begin
    if (state_r == psrl_pkg::ST_EVAL1) begin
      slot_r    <= hit_r ? hit_idx_r : (inv_r ? inv_idx_r : min_idx_r);
      new_end_r <= (item_r.now > ~psrl_pkg::ONE_SECOND_NS) ? '1 :
                   item_r.now + psrl_pkg::ONE_SECOND_NS;
      gt_r      <= item_r.now > hit_row_r.wend;
      ge_r      <= item_r.now >= hit_row_r.wend;
      diff_r    <= item_r.now - hit_row_r.wend;
      pk_inc_r  <= (hit_row_r.packets == psrl_pkg::PACKETS_MAX) ? hit_row_r.packets :
                   hit_row_r.packets + 32'd1;
      by_sum_r  <= by_wide[40] ? psrl_pkg::BYTES_MAX : by_wide[39:0];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (load_out) begin
      verdict_r <= verdict_nxt;
      cause_r   <= cause_nxt;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == psrl_pkg::ST_IDLE)
    else $error("queue popped outside idle");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == psrl_pkg::ST_CLEAR || state_r == psrl_pkg::ST_EVAL2))
    else $error("table written outside clear or update");

  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psrl_pkg::ST_EVAL2 && can_load) |=> out_tvalid)
    else $error("table update gave no result");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (verdict_r == psrl_pkg::VERDICT_PASS && (cause_r == psrl_pkg::CAUSE_NOT_IPV4 ||
        cause_r == psrl_pkg::CAUSE_WITHIN || cause_r == psrl_pkg::CAUSE_RELEASED)) ||
      (verdict_r == psrl_pkg::VERDICT_DROP && (cause_r == psrl_pkg::CAUSE_STILL ||
        cause_r == psrl_pkg::CAUSE_NEW_BLOCK)) ||
      (verdict_r == psrl_pkg::VERDICT_ABORT && cause_r == psrl_pkg::CAUSE_MALFORMED))
    else $error("verdict and cause disagree");

endmodule

FILE: hw/rtl/per_source_rate_limit_blocker.sv
// ----------------------------------------------------------------------------
// per_source_rate_limit_blocker: per-source packet rate limiter with blocking
// Frame headers enter on in_*; one verdict per frame leaves on out_*, in order.
// Limits and the release delay are set through the cfg_* register port.
//
// Each frame request is classified on entry and queued (four deep). Short
// and non-IPv4 frames are answered through the output register. IPv4
// frames are looked up by a scan of the source table, one entry per cycle
// through its single read port, then updated; the next frame is taken only
// after the update. A miss takes a free entry, else replaces the least
// recently used one. After reset the table is cleared one entry per cycle;
// meanwhile requests wait in the queue and in_tready drops once it is full.
// Register writes are taken at any time.
// A stalled receiver holds the verdict in the output register; the queue
// keeps accepting until full, then in_tready drops.
// ----------------------------------------------------------------------------
module per_source_rate_limit_blocker #(
  parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // frame_length, ether_kind, source_address, time_ns
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,   // verdict, cause, zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0] packet_limit_r;
  logic [31:0] byte_limit_r;
  logic [31:0] unblock_seconds_r;
  logic        unblock_enabled_r;
  logic [61:0] delay_r;
  logic        cfg_wr;

  psrl_pkg::cfg_t    cfg;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  psrl_pkg::q_item_t push_item;
  psrl_pkg::q_item_t q_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_limit_r    <= psrl_pkg::PACKET_LIMIT_RST;
      byte_limit_r      <= psrl_pkg::BYTE_LIMIT_RST;
      unblock_seconds_r <= '0;
      unblock_enabled_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        psrl_pkg::REG_PACKET_LIMIT:    packet_limit_r    <= cfg_pwdata;
        psrl_pkg::REG_BYTE_LIMIT:      byte_limit_r      <= cfg_pwdata;
        psrl_pkg::REG_UNBLOCK_SECONDS: unblock_seconds_r <= cfg_pwdata;
        psrl_pkg::REG_UNBLOCK_ENABLED: unblock_enabled_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read registers
  always_comb begin
    case (cfg_paddr[3:2])
      psrl_pkg::REG_PACKET_LIMIT:    cfg_prdata = packet_limit_r;
      psrl_pkg::REG_BYTE_LIMIT:      cfg_prdata = byte_limit_r;
      psrl_pkg::REG_UNBLOCK_SECONDS: cfg_prdata = unblock_seconds_r;
      psrl_pkg::REG_UNBLOCK_ENABLED: cfg_prdata = {31'd0, unblock_enabled_r};
      default:                       cfg_prdata = '0;
    endcase
  end

  // Convert the release delay to nanoseconds
  always_ff @(posedge clk) begin
    delay_r <= 62'(unblock_seconds_r) * 62'(psrl_pkg::ONE_SECOND_NS);
  end

  assign cfg.packet_limit    = packet_limit_r;
  assign cfg.byte_limit      = byte_limit_r;
  assign cfg.delay_ns        = delay_r;
  assign cfg.unblock_enabled = unblock_enabled_r;

  psrl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  psrl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  psrl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
